[src/chd_pkg.sv]
// ---------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helper functions of the canonical Huffman
// stream decoder.
// ---------------------------------------------------------------------------
package chd_pkg;

    localparam int MAX_LEVELS  = 16;
    localparam int ALPHA_SIZE  = 256;
    localparam int PREFIX_BITS = 8;
    localparam int PREFIX_SIZE = 256;
    localparam int MAX_RESULTS = 8;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_TOO_MANY_LEVELS = 3'd1,
        ST_ALPHABET_LONG   = 3'd2,
        ST_BAD_ESCAPE      = 3'd3,
        ST_LEVEL_OVERFLOW  = 3'd4,
        ST_INDEX_OVERFLOW  = 3'd5,
        ST_DATA_LEFT       = 3'd6
    } t_status;

    // stream phase
    typedef enum logic [1:0] {
        PH_LEVELS = 2'd0,
        PH_LEAVES = 2'd1,
        PH_ALPHA  = 2'd2,
        PH_CODES  = 2'd3
    } t_phase;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BINIT,
        S_BTOT,
        S_FRD,
        S_FWR,
        S_LOOK,
        S_PFX,
        S_LONG,
        S_ALW,
        S_GIVE,
        S_ERR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    take;
        logic    levels;
        logic    leaf;
        logic    alpha;
        logic    dec_load;
        logic    dec_spare;
        logic    dec_finish;
        logic    fail;
        t_status err_code;
        logic    build_init;
        logic    build_step;
        logic    fill_sel;
        logic    fill_next_w;
        logic    fill_wr;
        logic    pfx_hit;
        logic    long_start;
        logic    long_next;
        logic    long_hit;
        logic    alw;
        logic    give;
        logic    push_err;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic   halted;
        t_phase phase;
        logic   lc_bad;
        logic   lc_zero;
        logic   leaf_last;
        logic   sum_bad;
        logic   sum_zero;
        logic   alpha_last;
        logic   fin_now;
        logic   done;
        logic   spare_nz;
        logic   n_full;
        logic   tot_last;
        logic   fill_end;
        logic   leaf_more;
        logic   run_last;
        logic   esc;
        logic   w_gt_bc;
        logic   lvl_short;
        logic   lvl_over;
        logic   hit;
        logic   idx_bad;
        logic   out_free;
        logic   give_fin;
    } t_dp_stat;

    // top len bits of the first cnt bits of a buffer, zero filled below
    function automatic logic [15:0] top_bits(input logic [23:0] bits_in,
                                             input logic [4:0]  cnt,
                                             input logic [4:0]  len);
        logic [31:0] ext;
        logic [31:0] sh;
        logic [31:0] mask;
        ext  = {8'd0, bits_in};
        mask = (32'd1 << len) - 32'd1;
        if (len <= cnt) begin
            sh = ext >> (cnt - len);
        end else begin
            sh = ext << (len - cnt);
        end
        return sh[15:0] & mask[15:0];
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

[src/canonical_huffman_stream_decoder.sv]
// A header word is taken and dispatched; the last one also builds the level tables and fills
// the prefix table per leaf up to 8 bits, per code width and per filled entry. A code word is
// loaded into the bit buffer, each short symbol is found by the prefix table and each long
// symbol by comparing one level after another; each symbol also waits for a free output
// register. The next word is accepted only once the last one is done.
// Reset (synchronous, active low) and a stream start word clear the stream state.
// ---------------------------------------------------------------------------
// canonical_huffman_stream_decoder
// Top level: controller and datapath of the canonical Huffman decoder.
// ---------------------------------------------------------------------------
module canonical_huffman_stream_decoder import chd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] src_byte
    input  logic        i_s_axis_tuser,   // [0] stream_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte, [10:8] status
    output logic        o_m_axis_tlast    // last
);

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    chd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (s_stat),
        .o_cmd           (s_cmd)
    );

    chd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // a result is loaded only into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.give || s_cmd.push_err) |-> s_stat.out_free)
        else $error("result pushed into a full output register");

    // an error word carries a zero byte and closes the stream
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[10:8] != 3'd0)
            |-> (o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'd0))
        else $error("error word without last or with data");

    // a failure halts the stream
    a_fail_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.fail |=> s_stat.halted)
        else $error("failure did not halt the stream");

endmodule

[src/chd_ram.sv]
// ---------------------------------------------------------------------------
// chd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/chd_ctrl.sv]
// ---------------------------------------------------------------------------
// chd_ctrl
// Controller state machine: sequences header parsing, table build and the
// per-word decode loop, driving the datapath by commands.
// ---------------------------------------------------------------------------
module chd_ctrl import chd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_stat.halted) begin
                    n_state = S_IDLE;
                end else begin
                    case (i_stat.phase)
                        PH_LEVELS: begin
                            if (i_stat.lc_bad)       n_state = S_ERR;
                            else if (i_stat.lc_zero) n_state = S_BINIT;
                            else                     n_state = S_IDLE;
                        end
                        PH_LEAVES: begin
                            if (!i_stat.leaf_last)    n_state = S_IDLE;
                            else if (i_stat.sum_bad)  n_state = S_ERR;
                            else if (i_stat.sum_zero) n_state = S_BINIT;
                            else                      n_state = S_IDLE;
                        end
                        PH_ALPHA: begin
                            n_state = i_stat.alpha_last ? S_BINIT : S_IDLE;
                        end
                        default: begin
                            if (i_stat.fin_now)                       n_state = S_IDLE;
                            else if (i_stat.done && i_stat.spare_nz)  n_state = S_IDLE;
                            else if (i_stat.done)                     n_state = S_ERR;
                            else                                      n_state = S_LOOK;
                        end
                    endcase
                end
            end
            S_BINIT: n_state = S_BTOT;
            S_BTOT: begin
                if (i_stat.tot_last) n_state = S_FRD;
            end
            S_FRD: begin
                if (i_stat.fill_end)       n_state = S_IDLE;
                else if (i_stat.leaf_more) n_state = S_FWR;
            end
            S_FWR: begin
                if (i_stat.run_last) n_state = S_FRD;
            end
            S_LOOK: begin
                n_state = i_stat.n_full ? S_IDLE : S_PFX;
            end
            S_PFX: begin
                if (i_stat.esc)          n_state = S_LONG;
                else if (i_stat.w_gt_bc) n_state = S_IDLE;
                else                     n_state = S_GIVE;
            end
            S_LONG: begin
                if (i_stat.lvl_short)     n_state = S_IDLE;
                else if (i_stat.lvl_over) n_state = S_ERR;
                else if (i_stat.hit)      n_state = i_stat.idx_bad ? S_ERR : S_ALW;
            end
            S_ALW: n_state = S_GIVE;
            S_GIVE: begin
                if (i_stat.out_free) n_state = i_stat.give_fin ? S_IDLE : S_LOOK;
            end
            S_ERR: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = ST_OK;
        o_s_axis_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_s_axis_tvalid;
            end
            S_DISPATCH: begin
                if (!i_stat.halted) begin
                    case (i_stat.phase)
                        PH_LEVELS: begin
                            o_cmd.levels = 1'b1;
                            if (i_stat.lc_bad) begin
                                o_cmd.fail     = 1'b1;
                                o_cmd.err_code = ST_TOO_MANY_LEVELS;
                            end
                        end
                        PH_LEAVES: begin
                            o_cmd.leaf = 1'b1;
                            if (i_stat.leaf_last && i_stat.sum_bad) begin
                                o_cmd.fail     = 1'b1;
                                o_cmd.err_code = ST_ALPHABET_LONG;
                            end
                        end
                        PH_ALPHA: begin
                            o_cmd.alpha = 1'b1;
                        end
                        default: begin
                            if (i_stat.fin_now) begin
                                o_cmd.dec_finish = 1'b1;
                            end else if (i_stat.done && i_stat.spare_nz) begin
                                o_cmd.dec_spare = 1'b1;
                            end else if (i_stat.done) begin
                                o_cmd.fail     = 1'b1;
                                o_cmd.err_code = ST_DATA_LEFT;
                            end else begin
                                o_cmd.dec_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_BINIT: o_cmd.build_init = 1'b1;
            S_BTOT:  o_cmd.build_step = 1'b1;
            S_FRD: begin
                o_cmd.fill_sel = 1'b1;
                if (!i_stat.fill_end && !i_stat.leaf_more) o_cmd.fill_next_w = 1'b1;
            end
            S_FWR: begin
                o_cmd.fill_sel = 1'b1;
                o_cmd.fill_wr  = 1'b1;
            end
            S_LOOK: ;
            S_PFX: begin
                if (i_stat.esc)           o_cmd.long_start = 1'b1;
                else if (!i_stat.w_gt_bc) o_cmd.pfx_hit    = 1'b1;
            end
            S_LONG: begin
                if (!i_stat.lvl_short) begin
                    if (i_stat.lvl_over) begin
                        o_cmd.fail     = 1'b1;
                        o_cmd.err_code = ST_LEVEL_OVERFLOW;
                    end else if (i_stat.hit && i_stat.idx_bad) begin
                        o_cmd.fail     = 1'b1;
                        o_cmd.err_code = ST_INDEX_OVERFLOW;
                    end else if (i_stat.hit) begin
                        o_cmd.long_hit = 1'b1;
                    end else begin
                        o_cmd.long_next = 1'b1;
                    end
                end
            end
            S_ALW:  o_cmd.alw = 1'b1;
            S_GIVE: o_cmd.give = i_stat.out_free;
            S_ERR:  o_cmd.push_err = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[src/chd_dp.sv]
// ---------------------------------------------------------------------------
// chd_dp
// Datapath: header registers, level tables, alphabet and prefix memories,
// bit buffer, symbol output and the result register.
// ---------------------------------------------------------------------------
module chd_dp import chd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tuser,
    input  logic        i_m_axis_tready,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_m_axis_tvalid,
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam logic [0:0] CFG_OUT_LENGTH = 1'b0;
    localparam logic [0:0] CFG_REVERSE    = 1'b1;

    // configuration
    logic [23:0] r_olen;
    logic        r_rev;

    // stream control state
    t_phase      r_phase;
    logic [4:0]  r_lc;
    logic        r_delta;
    logic [11:0] r_sum;
    logic [8:0]  r_hi;
    logic [8:0]  r_alen;
    logic [23:0] r_buf;
    logic [4:0]  r_bc;
    logic [7:0]  r_prev;
    logic [23:0] r_ocnt;
    logic        r_done;
    logic [1:0]  r_spare;
    logic        r_halt;
    logic [3:0]  r_n;
    logic [4:0]  r_level;
    logic        r_ovalid;

    // build counters
    logic [23:0] r_codes;
    logic [8:0]  r_alph;
    logic [3:0]  r_lv;
    logic [3:0]  r_w;
    logic [7:0]  r_k;
    logic [7:0]  r_ai;
    logic [8:0]  r_fill;
    logic [7:0]  r_run;

    // payload
    logic [7:0]  r_byte;
    logic [7:0]  r_sym;
    logic [7:0]  r_obyte;
    t_status     r_ostat;
    logic        r_olast;
    t_status     r_err;
    logic [7:0]  r_leaf [MAX_LEVELS];
    logic [23:0] r_tot  [MAX_LEVELS];
    logic [24:0] r_off  [MAX_LEVELS];

    // combinational terms
    logic [11:0] n_sum;
    logic [23:0] n_ocnt;
    logic [7:0]  n_val;
    logic [7:0]  code8;
    logic [15:0] v16;
    logic [3:0]  lvi;
    logic signed [25:0] idx;
    logic [23:0] codes2;
    logic [7:0]  leaves;
    logic [3:0]  maxw;
    logic [7:0]  run;
    logic [7:0]  alpha_rdata;
    logic [11:0] pfx_rdata;
    logic [7:0]  alpha_raddr;
    logic        out_free;
    logic        clear;

    assign clear    = i_cmd.take && i_s_axis_tuser;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign n_sum    = r_sum + {4'd0, r_byte};
    assign n_ocnt   = r_ocnt + 24'd1;
    assign n_val    = r_delta ? (r_prev + r_sym) : r_sym;
    assign code8    = 8'(top_bits(r_buf, r_bc, 5'(PREFIX_BITS)));
    assign v16      = top_bits(r_buf, r_bc, r_level + 5'd1);
    assign lvi      = r_level[3:0];
    assign idx      = $signed({10'd0, v16}) + $signed({r_off[lvi][24], r_off[lvi]});
    assign codes2   = {r_codes[22:0], 1'b0};
    assign leaves   = ({1'b0, r_lv} < r_lc) ? r_leaf[r_lv] : 8'd0;
    assign maxw     = (r_lc < 5'(PREFIX_BITS)) ? r_lc[3:0] : 4'(PREFIX_BITS);
    assign run      = 8'd1 << (4'(PREFIX_BITS) - r_w);
    assign alpha_raddr = i_cmd.fill_sel ? r_ai : idx[7:0];

    // status toward the controller
    always_comb begin
        o_stat.halted     = r_halt;
        o_stat.phase      = r_phase;
        o_stat.lc_bad     = r_byte[6:0] > 7'(MAX_LEVELS);
        o_stat.lc_zero    = r_byte[6:0] == 7'd0;
        o_stat.leaf_last  = ({1'b0, r_hi} + 10'd1) >= {5'd0, r_lc};
        o_stat.sum_bad    = n_sum > 12'(ALPHA_SIZE);
        o_stat.sum_zero   = n_sum == 12'd0;
        o_stat.alpha_last = ({1'b0, r_hi} + 10'd1) >= {1'b0, r_alen};
        o_stat.fin_now    = !r_done && (r_ocnt >= r_olen);
        o_stat.done       = r_done;
        o_stat.spare_nz   = r_spare != 2'd0;
        o_stat.n_full     = r_n == 4'(MAX_RESULTS);
        o_stat.tot_last   = r_lv == 4'(MAX_LEVELS - 1);
        o_stat.fill_end   = r_fill[8] || (r_w > maxw);
        o_stat.leaf_more  = r_k < r_leaf[r_w - 4'd1];
        o_stat.run_last   = ((r_run + 8'd1) == run) || (r_fill == 9'(PREFIX_SIZE - 1));
        o_stat.esc        = {1'b0, code8} >= r_fill;
        o_stat.w_gt_bc    = {1'b0, pfx_rdata[11:8]} > r_bc;
        o_stat.lvl_short  = r_bc < (r_level + 5'd1);
        o_stat.lvl_over   = r_level >= 5'(MAX_LEVELS);
        o_stat.hit        = {8'd0, v16} < r_tot[lvi];
        o_stat.idx_bad    = idx[25:8] != 18'd0;
        o_stat.out_free   = out_free;
        o_stat.give_fin   = n_ocnt >= r_olen;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olen   <= '0;
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_OUT_LENGTH) r_olen <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_REVERSE)    r_rev  <= i_cfg_data[0];
            if (i_cmd.give || i_cmd.push_err) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // stream state: cleared by reset and by a stream start word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_phase <= PH_LEVELS;
            r_lc    <= '0;
            r_delta <= 1'b0;
            r_sum   <= '0;
            r_hi    <= '0;
            r_alen  <= '0;
            r_buf   <= '0;
            r_bc    <= '0;
            r_prev  <= '0;
            r_ocnt  <= '0;
            r_done  <= 1'b0;
            r_spare <= '0;
            r_halt  <= 1'b0;
            r_n     <= '0;
            r_level <= '0;
            r_fill  <= '0;
            r_codes <= '0;
            r_alph  <= '0;
            r_lv    <= '0;
            r_w     <= 4'd1;
            r_k     <= '0;
            r_ai    <= '0;
            r_run   <= '0;
        end else begin
            if (i_cmd.fail) r_halt <= 1'b1;
            // header
            if (i_cmd.levels) begin
                r_delta <= r_byte[7];
                if (!o_stat.lc_bad) begin
                    r_lc   <= r_byte[4:0];
                    r_hi   <= '0;
                    r_sum  <= '0;
                    r_alen <= '0;
                    if (!o_stat.lc_zero) r_phase <= PH_LEAVES;
                end
            end
            if (i_cmd.leaf) begin
                r_sum <= n_sum;
                if (o_stat.leaf_last) begin
                    r_alen <= n_sum[8:0];
                    r_hi   <= '0;
                    if (!o_stat.sum_bad && !o_stat.sum_zero) r_phase <= PH_ALPHA;
                end else begin
                    r_hi <= r_hi + 9'd1;
                end
            end
            if (i_cmd.alpha) r_hi <= r_hi + 9'd1;
            // table build
            if (i_cmd.build_init) begin
                r_phase <= PH_CODES;
                r_codes <= '0;
                r_alph  <= '0;
                r_lv    <= '0;
                r_w     <= 4'd1;
                r_k     <= '0;
                r_ai    <= '0;
                r_fill  <= '0;
                r_run   <= '0;
                r_bc    <= '0;
            end
            if (i_cmd.build_step) begin
                r_codes <= codes2 + {16'd0, leaves};
                r_alph  <= r_alph + {1'b0, leaves};
                r_lv    <= r_lv + 4'd1;
            end
            if (i_cmd.fill_next_w) begin
                r_w <= r_w + 4'd1;
                r_k <= '0;
            end
            if (i_cmd.fill_wr) begin
                r_fill <= r_fill + 9'd1;
                if (o_stat.run_last) begin
                    r_run <= '0;
                    r_k   <= r_k + 8'd1;
                    r_ai  <= r_ai + 8'd1;
                end else begin
                    r_run <= r_run + 8'd1;
                end
            end
            // decode
            if (i_cmd.dec_finish) begin
                r_done  <= 1'b1;
                r_spare <= (r_ocnt != 24'd0) ? 2'd0 : 2'd1;
            end
            if (i_cmd.dec_spare) r_spare <= r_spare - 2'd1;
            if (i_cmd.dec_load) begin
                r_buf <= {r_buf[15:0], r_rev ? reverse8(r_byte) : r_byte};
                r_bc  <= r_bc + 5'd8;
                r_n   <= '0;
            end
            if (i_cmd.pfx_hit)    r_bc    <= r_bc - {1'b0, pfx_rdata[11:8]};
            if (i_cmd.long_start) r_level <= 5'(PREFIX_BITS);
            if (i_cmd.long_next)  r_level <= r_level + 5'd1;
            if (i_cmd.long_hit)   r_bc    <= r_bc - (r_level + 5'd1);
            if (i_cmd.give) begin
                r_prev <= n_val;
                r_ocnt <= n_ocnt;
                r_n    <= r_n + 4'd1;
                if (o_stat.give_fin) begin
                    r_done  <= 1'b1;
                    r_spare <= 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take)    r_byte <= i_s_axis_tdata;
        if (i_cmd.leaf)    r_leaf[r_hi[3:0]] <= r_byte;
        if (i_cmd.build_step) begin
            r_off[r_lv] <= {16'd0, r_alph} - {1'b0, codes2};
            r_tot[r_lv] <= codes2 + {16'd0, leaves};
        end
        if (i_cmd.fail)    r_err <= i_cmd.err_code;
        if (i_cmd.pfx_hit) r_sym <= pfx_rdata[7:0];
        if (i_cmd.alw)     r_sym <= alpha_rdata;
        if (i_cmd.give) begin
            r_obyte <= n_val;
            r_ostat <= ST_OK;
            r_olast <= o_stat.give_fin;
        end else if (i_cmd.push_err) begin
            r_obyte <= 8'd0;
            r_ostat <= r_err;
            r_olast <= 1'b1;
        end
    end

    // alphabet memory
    chd_ram #(.WIDTH(8), .DEPTH(ALPHA_SIZE)) u_alpha_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alpha),
        .i_waddr (r_hi[7:0]),
        .i_wdata (r_byte),
        .i_raddr (alpha_raddr),
        .o_rdata (alpha_rdata)
    );

    // prefix table: code width over symbol
    chd_ram #(.WIDTH(12), .DEPTH(PREFIX_SIZE)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_wr),
        .i_waddr (r_fill[7:0]),
        .i_wdata ({r_w, alpha_rdata}),
        .i_raddr (code8),
        .o_rdata (pfx_rdata)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_ostat, r_obyte};
    assign o_m_axis_tlast  = r_olast;

endmodule
